// ----- src/lcab_pkg.sv -----
// lcab_pkg: shared types and constants for the tree ancestor block
// datapath micro-operation codes and the status word seen by the controller
// no dependencies
`default_nettype none

package lcab_pkg;

  localparam int ID_W    = 10;
  localparam int LEN_W   = 11;
  localparam int DEP_W   = ID_W + 1;
  localparam int CMP_W   = 17;
  localparam int OP_W    = 5;

  localparam logic [ID_W-1:0] DEPTH_MAX = 10'd1023;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_IDLE    = 5'd0;
  localparam op_t OP_CLR     = 5'd1;
  localparam op_t OP_A_ROOT  = 5'd2;
  localparam op_t OP_A_DEP   = 5'd3;
  localparam op_t OP_A_FIRST = 5'd4;
  localparam op_t OP_A_RD    = 5'd5;
  localparam op_t OP_A_WR    = 5'd6;
  localparam op_t OP_Q_RDA   = 5'd7;
  localparam op_t OP_Q_RDB   = 5'd8;
  localparam op_t OP_Q_SWAP  = 5'd9;
  localparam op_t OP_L_RD    = 5'd10;
  localparam op_t OP_L_UP    = 5'd11;
  localparam op_t OP_L_DEP   = 5'd12;
  localparam op_t OP_K_DEC   = 5'd13;
  localparam op_t OP_C_SELF  = 5'd14;
  localparam op_t OP_P_INIT  = 5'd15;
  localparam op_t OP_P_RA    = 5'd16;
  localparam op_t OP_P_RB    = 5'd17;
  localparam op_t OP_P_CMP   = 5'd18;
  localparam op_t OP_P_FA    = 5'd19;
  localparam op_t OP_P_FB    = 5'd20;
  localparam op_t OP_F_RD    = 5'd21;
  localparam op_t OP_F_C     = 5'd22;
  localparam op_t OP_F_OUT   = 5'd23;
  localparam op_t OP_NOP     = 5'd24;

  typedef struct packed {
    logic query;
    logic add_ok;
    logic root;
    logic clr_done;
    logic k_zero;
    logic k_top;
    logic lift;
    logic same;
    logic differ;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/lcab_ram.sv -----
// lcab_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module lcab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- src/lcab_dp.sv -----
// lcab_dp: datapath with depth and ancestor memories and the walk registers
// depends on lcab_pkg and lcab_ram; driven one micro-operation per cycle
`default_nettype none

module lcab_dp #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lcab_pkg::op_t               op,
  input  wire logic                        in_req_type,
  input  wire logic [lcab_pkg::ID_W-1:0]   in_node_id,
  input  wire logic [lcab_pkg::ID_W-1:0]   in_other_id,
  output lcab_pkg::stat_t                  stat,
  output logic                             out_valid,
  output logic      [lcab_pkg::ID_W-1:0]   out_common_ancestor,
  output logic      [lcab_pkg::LEN_W-1:0]  out_path_length
);

  import lcab_pkg::*;

  localparam int N_EFF     = (MAX_NODES > (1 << ID_W)) ? (1 << ID_W) : MAX_NODES;
  localparam int NW        = $clog2(N_EFF);
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_DEPTH = N_EFF * (2 ** LW);
  localparam int AAW       = $clog2(ANC_DEPTH);
  localparam logic [CMP_W-1:0] MAXN   = CMP_W'(MAX_NODES);
  localparam logic [LW-1:0]    K_LAST = LW'(LEVELS - 1);

  logic            type_r;
  logic            add_ok_r;
  logic [NW-1:0]   a_r, b_r, cur_r, ua_r, c_r, clr_r;
  logic            fa_r, fb_r;
  logic [ID_W-1:0] da_r, db_r;
  logic [LEN_W-1:0] sum_r;
  logic [LW-1:0]   k_r;
  logic            out_valid_r;
  logic [ID_W-1:0] out_ca_r;
  logic [LEN_W-1:0] out_len_r;

  logic             dep_we;
  logic [NW-1:0]    dep_waddr, dep_raddr;
  logic [DEP_W-1:0] dep_wdata, dep_q;
  logic             anc_we;
  logic [AAW-1:0]   anc_waddr, anc_raddr;
  logic [NW-1:0]    anc_wdata, anc_q;

  logic            node_ok, other_ok;
  logic [NW-1:0]   node_idx, other_idx;
  logic            dep_flag;
  logic [ID_W-1:0] dep_val, d_sat;
  logic [NW-1:0]   gate_a, gate_b, cur_v;
  logic [CMP_W-1:0] lift_rhs;
  logic signed [LEN_W+1:0] len_s;

  lcab_ram #(.WIDTH(DEP_W), .DEPTH(N_EFF)) u_depth (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_q)
  );

  lcab_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH)) u_anc (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_q)
  );

  assign node_ok   = CMP_W'(in_node_id) < MAXN;
  assign other_ok  = CMP_W'(in_other_id) < MAXN;
  assign node_idx  = node_ok ? in_node_id[NW-1:0] : '0;
  assign other_idx = other_ok ? in_other_id[NW-1:0] : '0;

  assign dep_flag = dep_q[DEP_W-1];
  assign dep_val  = dep_q[ID_W-1:0];
  assign d_sat    = (dep_val == DEPTH_MAX) ? dep_val : dep_val + 1'b1;
  assign gate_a   = fa_r ? anc_q : '0;
  assign gate_b   = fb_r ? anc_q : '0;
  assign cur_v    = dep_flag ? anc_q : '0;
  assign lift_rhs = CMP_W'(db_r) + (CMP_W'(1) << k_r);
  assign len_s    = $signed({2'b00, sum_r}) - $signed({2'b00, dep_val, 1'b0});

  always_comb begin
    stat.query    = type_r;
    stat.add_ok   = add_ok_r;
    stat.root     = (b_r == '0);
    stat.clr_done = (clr_r == NW'(N_EFF - 1));
    stat.k_zero   = (k_r == '0);
    stat.k_top    = (k_r == K_LAST);
    stat.lift     = CMP_W'(da_r) >= lift_rhs;
    stat.same     = (a_r == b_r);
    stat.differ   = (ua_r != gate_b);
  end

  // memory ports
  always_comb begin
    dep_we    = 1'b0;
    dep_waddr = a_r;
    dep_wdata = '0;
    dep_raddr = a_r;
    anc_we    = 1'b0;
    anc_waddr = {a_r, k_r};
    anc_wdata = b_r;
    anc_raddr = {a_r, k_r};
    case (op)
      OP_CLR: begin
        dep_we    = 1'b1;
        dep_waddr = clr_r;
      end
      OP_A_ROOT: begin
        dep_we = 1'b1;
      end
      OP_A_DEP: begin
        dep_raddr = b_r;
      end
      OP_A_FIRST: begin
        dep_we    = 1'b1;
        dep_wdata = {1'b1, d_sat};
        anc_we    = 1'b1;
        anc_waddr = {a_r, {LW{1'b0}}};
      end
      OP_A_RD: begin
        dep_raddr = cur_r;
        anc_raddr = {cur_r, k_r - 1'b1};
      end
      OP_A_WR: begin
        anc_we    = 1'b1;
        anc_wdata = cur_v;
      end
      OP_Q_RDB: begin
        dep_raddr = b_r;
      end
      OP_L_UP: begin
        dep_raddr = gate_a;
      end
      OP_P_RB: begin
        anc_raddr = {b_r, k_r};
      end
      OP_P_CMP: begin
        dep_raddr = ua_r;
      end
      OP_P_FA: begin
        dep_raddr = b_r;
      end
      OP_F_RD: begin
        anc_raddr = {a_r, {LW{1'b0}}};
      end
      OP_F_C: begin
        dep_raddr = gate_a;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (op == OP_F_OUT);
      if (op == OP_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    case (op)
      OP_IDLE: begin
        type_r   <= in_req_type;
        a_r      <= node_idx;
        b_r      <= other_idx;
        add_ok_r <= node_ok && (node_idx != '0);
      end
      OP_A_FIRST: begin
        cur_r <= b_r;
        k_r   <= LW'(1);
      end
      OP_A_WR: begin
        cur_r <= cur_v;
        k_r   <= k_r + 1'b1;
      end
      OP_Q_RDB: begin
        fa_r <= dep_flag;
        da_r <= dep_val;
      end
      OP_Q_SWAP: begin
        sum_r <= LEN_W'(da_r) + LEN_W'(dep_val);
        k_r   <= K_LAST;
        if (da_r < dep_val) begin
          a_r  <= b_r;
          b_r  <= a_r;
          fa_r <= dep_flag;
          da_r <= dep_val;
          fb_r <= fa_r;
          db_r <= da_r;
        end else begin
          fb_r <= dep_flag;
          db_r <= dep_val;
        end
      end
      OP_L_UP: begin
        a_r <= gate_a;
      end
      OP_L_DEP: begin
        fa_r <= dep_flag;
        da_r <= dep_val;
        k_r  <= k_r - 1'b1;
      end
      OP_K_DEC: begin
        k_r <= k_r - 1'b1;
      end
      OP_C_SELF: begin
        c_r <= a_r;
      end
      OP_P_INIT: begin
        k_r <= K_LAST;
      end
      OP_P_RB: begin
        ua_r <= gate_a;
      end
      OP_P_CMP: begin
        if (ua_r != gate_b) begin
          a_r <= ua_r;
          b_r <= gate_b;
        end else begin
          k_r <= k_r - 1'b1;
        end
      end
      OP_P_FA: begin
        fa_r <= dep_flag;
      end
      OP_P_FB: begin
        fb_r <= dep_flag;
        k_r  <= k_r - 1'b1;
      end
      OP_F_C: begin
        c_r <= gate_a;
      end
      OP_F_OUT: begin
        out_ca_r  <= ID_W'(c_r);
        out_len_r <= len_s[LEN_W+1] ? '0 : len_s[LEN_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_common_ancestor = out_ca_r;
  assign out_path_length     = out_len_r;

endmodule

`default_nettype wire

// ----- src/lcab_ctrl.sv -----
// lcab_ctrl: sequencer for the clearing sweep, node adds and ancestor queries
// depends on lcab_pkg; issues one datapath micro-operation per cycle
`default_nettype none

module lcab_ctrl #(
  parameter int LEVELS = 10
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire lcab_pkg::stat_t stat,
  output lcab_pkg::op_t        op,
  output logic                 busy
);

  import lcab_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_AROOT  = 5'd3;
  localparam logic [4:0] S_ADEP   = 5'd4;
  localparam logic [4:0] S_AFIRST = 5'd5;
  localparam logic [4:0] S_ARD    = 5'd6;
  localparam logic [4:0] S_AWR    = 5'd7;
  localparam logic [4:0] S_QA     = 5'd8;
  localparam logic [4:0] S_QB     = 5'd9;
  localparam logic [4:0] S_QSW    = 5'd10;
  localparam logic [4:0] S_LCHK   = 5'd11;
  localparam logic [4:0] S_LUP    = 5'd12;
  localparam logic [4:0] S_LDEP   = 5'd13;
  localparam logic [4:0] S_SAME   = 5'd14;
  localparam logic [4:0] S_PRA    = 5'd15;
  localparam logic [4:0] S_PRB    = 5'd16;
  localparam logic [4:0] S_PCMP   = 5'd17;
  localparam logic [4:0] S_PFA    = 5'd18;
  localparam logic [4:0] S_PFB    = 5'd19;
  localparam logic [4:0] S_FRD    = 5'd20;
  localparam logic [4:0] S_FC     = 5'd21;
  localparam logic [4:0] S_OUT    = 5'd22;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    case (state_r)
      S_CLR: begin
        op = OP_CLR;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        op = OP_IDLE;
        if (start) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.query) begin
          state_nxt = S_QA;
        end else if (!stat.add_ok) begin
          state_nxt = S_IDLE;
        end else if (stat.root) begin
          state_nxt = S_AROOT;
        end else begin
          state_nxt = S_ADEP;
        end
      end
      S_AROOT: begin
        op        = OP_A_ROOT;
        state_nxt = S_IDLE;
      end
      S_ADEP: begin
        op        = OP_A_DEP;
        state_nxt = S_AFIRST;
      end
      S_AFIRST: begin
        op        = OP_A_FIRST;
        state_nxt = (LEVELS > 1) ? S_ARD : S_IDLE;
      end
      S_ARD: begin
        op        = OP_A_RD;
        state_nxt = S_AWR;
      end
      S_AWR: begin
        op        = OP_A_WR;
        state_nxt = stat.k_top ? S_IDLE : S_ARD;
      end
      S_QA: begin
        op        = OP_Q_RDA;
        state_nxt = S_QB;
      end
      S_QB: begin
        op        = OP_Q_RDB;
        state_nxt = S_QSW;
      end
      S_QSW: begin
        op        = OP_Q_SWAP;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (stat.lift) begin
          op        = OP_L_RD;
          state_nxt = S_LUP;
        end else begin
          op        = OP_K_DEC;
          state_nxt = stat.k_zero ? S_SAME : S_LCHK;
        end
      end
      S_LUP: begin
        op        = OP_L_UP;
        state_nxt = S_LDEP;
      end
      S_LDEP: begin
        op        = OP_L_DEP;
        state_nxt = stat.k_zero ? S_SAME : S_LCHK;
      end
      S_SAME: begin
        if (stat.same) begin
          op        = OP_C_SELF;
          state_nxt = S_OUT;
        end else begin
          op        = OP_P_INIT;
          state_nxt = S_PRA;
        end
      end
      S_PRA: begin
        op        = OP_P_RA;
        state_nxt = S_PRB;
      end
      S_PRB: begin
        op        = OP_P_RB;
        state_nxt = S_PCMP;
      end
      S_PCMP: begin
        op = OP_P_CMP;
        if (stat.differ) begin
          state_nxt = S_PFA;
        end else begin
          state_nxt = stat.k_zero ? S_FRD : S_PRA;
        end
      end
      S_PFA: begin
        op        = OP_P_FA;
        state_nxt = S_PFB;
      end
      S_PFB: begin
        op        = OP_P_FB;
        state_nxt = stat.k_zero ? S_FRD : S_PRA;
      end
      S_FRD: begin
        op        = OP_F_RD;
        state_nxt = S_FC;
      end
      S_FC: begin
        op        = OP_F_C;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        op        = OP_F_OUT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ----- src/tree_lca_distance_binary_lifting.sv -----
// tree_lca_distance_binary_lifting: rooted tree store with ancestor queries
// depends on lcab_pkg, lcab_ctrl and lcab_dp
//
// usage
//   a word is taken when start is high and busy is low. in_req_type 0 adds
//   in_node_id under parent in_other_id (parent 0 makes it a root); 1 asks for
//   the lowest common ancestor of in_node_id and in_other_id.
//   a query answers with one word on out_common_ancestor / out_path_length,
//   marked by out_valid for exactly one cycle; an add gives no word.
//   the receiver cannot hold results off; out_valid rises as busy falls,
//   and a new word may be taken in that same cycle.
// operation
//   the walk steps go through the depth and ancestor memories (one read port each,
//   registered data), so the walk is memory-bound.
//   add: writes the depth and first ancestor, then each higher ancestor level;
//   a root writes only its depth, an ignored add writes nothing. query: a lifting
//   pass, then, when the nodes differ, a joint pass and a final read.
// reset
//   rst_n clears the controller, then busy stays high while the depth memory
//   is swept to zero.
`default_nettype none

module tree_lca_distance_binary_lifting #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_req_type,
  input  wire logic [lcab_pkg::ID_W-1:0]   in_node_id,
  input  wire logic [lcab_pkg::ID_W-1:0]   in_other_id,
  output logic                             out_valid,
  output logic      [lcab_pkg::ID_W-1:0]   out_common_ancestor,
  output logic      [lcab_pkg::LEN_W-1:0]  out_path_length
);

  import lcab_pkg::*;

  op_t   op;
  stat_t stat;

  lcab_ctrl #(.LEVELS(LEVELS)) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy)
  );

  lcab_dp #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .in_req_type         (in_req_type),
    .in_node_id          (in_node_id),
    .in_other_id         (in_other_id),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_common_ancestor (out_common_ancestor),
    .out_path_length     (out_path_length)
  );

endmodule

`default_nettype wire
